/* design/dcs_pkg.sv */
// ----------------------------------------------------------------------------
// dcs_pkg: shared types and constants for dose coverage statistics
// Holds statistic codes, the dose level table and the update control struct.
// ----------------------------------------------------------------------------
package dcs_pkg;

  localparam int PRESC_W    = 16;
  localparam int VALUE_W    = 40;
  localparam int CODE_W     = 4;
  localparam int NUM_LEVELS = 8;
  localparam int NUM_STATS  = 14;
  localparam int PCT_W      = 7;

  // Dose levels in percent of the prescription.
  localparam logic [PCT_W-1:0] LEVEL_PCT [NUM_LEVELS] = '{
    7'd90, 7'd95, 7'd98, 7'd100, 7'd105, 7'd107, 7'd110, 7'd120
  };

  localparam logic [PCT_W-1:0] DOSE_SCALE = 7'd100;

  typedef enum logic [CODE_W-1:0] {
    CODE_TGT_MIN = 4'd0,
    CODE_TGT_MAX = 4'd1,
    CODE_TGT_SUM = 4'd2,
    CODE_LVL_90  = 4'd3,
    CODE_LVL_95  = 4'd4,
    CODE_LVL_98  = 4'd5,
    CODE_LVL_100 = 4'd6,
    CODE_LVL_105 = 4'd7,
    CODE_LVL_107 = 4'd8,
    CODE_LVL_110 = 4'd9,
    CODE_LVL_120 = 4'd10,
    CODE_ORG_MIN = 4'd11,
    CODE_ORG_MAX = 4'd12,
    CODE_ORG_SUM = 4'd13
  } stat_code_e;

  // Update control from the input stage to the accumulators.
  typedef struct packed {
    logic apply;  // a voxel word is retired this cycle
    logic last;   // that word closes the volume: clear after it
  } upd_t;

endpackage

/* design/dcs_track.sv */
// ----------------------------------------------------------------------------
// dcs_track: minimum, maximum and saturating sum of dose for one voxel set
// Presents the post-update values and clears to the empty set on last word.
// ----------------------------------------------------------------------------
module dcs_track #(
  parameter int DOSE_BITS = 16,
  parameter int SUM_W     = 40
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dcs_pkg::upd_t        upd_i,
  input  logic                 hit_i,
  input  logic [DOSE_BITS-1:0] dose_i,
  output logic [DOSE_BITS-1:0] min_nx_o,
  output logic [DOSE_BITS-1:0] max_nx_o,
  output logic [SUM_W-1:0]     sum_nx_o
);

  logic [DOSE_BITS-1:0] min_q, max_q;
  logic [SUM_W-1:0]     sum_q;
  logic [SUM_W:0]       sum_ext;
  logic                 take;

  assign take    = upd_i.apply & hit_i;
  assign sum_ext = {1'b0, sum_q} + (SUM_W+1)'(dose_i);

  always_comb begin
    min_nx_o = min_q;
    max_nx_o = max_q;
    sum_nx_o = sum_q;
    if (take) begin
      if (dose_i < min_q) min_nx_o = dose_i;
      if (dose_i > max_q) max_nx_o = dose_i;
      // saturate on carry out of the sum width
      sum_nx_o = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= '1;
      max_q <= '0;
      sum_q <= '0;
    end else if (upd_i.apply && upd_i.last) begin
      min_q <= '1;
      max_q <= '0;
      sum_q <= '0;
    end else begin
      min_q <= min_nx_o;
      max_q <= max_nx_o;
      sum_q <= sum_nx_o;
    end
  end

endmodule

/* design/dcs_level.sv */
// ----------------------------------------------------------------------------
// dcs_level: dose level thresholds and saturating target voxel counters
// Holds prescription times each level; counts voxels with dose*100 at or above.
// ----------------------------------------------------------------------------
module dcs_level #(
  parameter int DOSE_BITS = 16,
  parameter int CNT_W     = 25
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [dcs_pkg::PRESC_W-1:0] cfg_wdata_i,
  input  dcs_pkg::upd_t               upd_i,
  input  logic                        hit_i,
  input  logic [DOSE_BITS-1:0]        dose_i,
  output logic [CNT_W-1:0]            cnt_nx_o [dcs_pkg::NUM_LEVELS]
);

  localparam int ThrW = dcs_pkg::PRESC_W + dcs_pkg::PCT_W;
  localparam int CmpW = (DOSE_BITS > dcs_pkg::PRESC_W ? DOSE_BITS : dcs_pkg::PRESC_W)
                        + dcs_pkg::PCT_W;

  logic [ThrW-1:0]  thr_q [dcs_pkg::NUM_LEVELS];
  logic [CNT_W-1:0] cnt_q [dcs_pkg::NUM_LEVELS];
  logic [CmpW-1:0]  dose_x100;

  assign dose_x100 = CmpW'(dose_i) * CmpW'(dcs_pkg::DOSE_SCALE);

  always_comb begin
    for (int i = 0; i < dcs_pkg::NUM_LEVELS; i++) begin
      cnt_nx_o[i] = cnt_q[i];
      if (upd_i.apply && hit_i && (dose_x100 >= CmpW'(thr_q[i])) && (cnt_q[i] != '1)) begin
        cnt_nx_o[i] = cnt_q[i] + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < dcs_pkg::NUM_LEVELS; i++) begin
        thr_q[i] <= '0;
        cnt_q[i] <= '0;
      end
    end else begin
      for (int i = 0; i < dcs_pkg::NUM_LEVELS; i++) begin
        if (cfg_we_i) begin
          thr_q[i] <= ThrW'(cfg_wdata_i) * ThrW'(dcs_pkg::LEVEL_PCT[i]);
        end
        cnt_q[i] <= (upd_i.apply && upd_i.last) ? '0 : cnt_nx_o[i];
      end
    end
  end

endmodule

/* design/dcs_report.sv */
// ----------------------------------------------------------------------------
// dcs_report: report snapshot and word serialiser
// Captures all statistics at once and sends them out one word per code.
// ----------------------------------------------------------------------------
module dcs_report (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        load_i,
  input  logic [dcs_pkg::VALUE_W-1:0] vals_i [dcs_pkg::NUM_STATS],
  output logic                        free_o,
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  output logic [dcs_pkg::VALUE_W-1:0] m_axis_tdata_o,
  output logic [dcs_pkg::CODE_W-1:0]  m_axis_tuser_o,
  output logic                        m_axis_tlast_o
);

  logic [dcs_pkg::VALUE_W-1:0] snap_q [dcs_pkg::NUM_STATS];
  dcs_pkg::stat_code_e         code_q, code_d;
  logic                        busy_q, busy_d;
  logic                        fire, end_word;

  assign fire     = busy_q & m_axis_tready_i;
  assign end_word = (code_q == dcs_pkg::CODE_ORG_SUM);
  assign free_o   = !busy_q || (fire && end_word);

  assign m_axis_tvalid_o = busy_q;
  assign m_axis_tdata_o  = snap_q[code_q];
  assign m_axis_tuser_o  = code_q;
  assign m_axis_tlast_o  = end_word;

  always_comb begin
    busy_d = busy_q;
    code_d = code_q;
    if (fire) begin
      if (end_word) begin
        busy_d = 1'b0;
      end else begin
        code_d = dcs_pkg::stat_code_e'(code_q + 4'd1);
      end
    end
    if (load_i) begin
      busy_d = 1'b1;
      code_d = dcs_pkg::CODE_TGT_MIN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      code_q <= dcs_pkg::CODE_TGT_MIN;
    end else begin
      busy_q <= busy_d;
      code_q <= code_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      snap_q <= vals_i;
    end
  end

endmodule

/* design/dose_coverage_statistics.sv */
// ----------------------------------------------------------------------------
// dose_coverage_statistics: per-volume dose statistics over a voxel stream
// Tracks target and organ-at-risk min/max/sum and target dose level counts.
// ----------------------------------------------------------------------------
// Usage:
//   Voxel words enter on the s_axis channel: tdata carries the dose, tuser
//   the region flags and tlast marks the final voxel of a volume. One word
//   is taken per cycle while no final voxel is held; each word waits in the
//   input register and is folded into the accumulators (compare and add).
//   cfg_we_i / cfg_wdata_i write the prescription dose; write it only while
//   no word is in flight. Each level threshold is registered at that write.
//   When the final voxel is retired, all 14 statistics are captured into a
//   report snapshot and the accumulators return to the empty set, so the
//   next volume streams straight on. The first report word is valid once
//   the snapshot has been loaded; the report then leaves on m_axis at one
//   word per cycle while the receiver is ready, in code order, tuser holding
//   the code and tlast set on the organ sum.
//   Voxels are taken at one per cycle, but a final voxel holds in the input
//   register (tready low) until the previous report has fully drained.
//   A receiver stall holds the current report word and only back-pressures
//   the input once a further final voxel arrives.
//   Reset clears the prescription, the accumulators and both valid flags.
// ----------------------------------------------------------------------------
module dose_coverage_statistics #(
  parameter int MAX_VOXELS_LOG2 = 24,
  parameter int DOSE_BITS       = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration
  input  logic                        cfg_we_i,
  input  logic [dcs_pkg::PRESC_W-1:0] cfg_wdata_i,
  // voxel input
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  logic [((DOSE_BITS+7)/8)*8-1:0] s_axis_tdata_i,  // voxel_dose
  input  logic [2:0]                  s_axis_tuser_i,  // in_roi, in_target, in_organ
  input  logic                        s_axis_tlast_i,  // final_voxel
  // report output
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  output logic [dcs_pkg::VALUE_W-1:0] m_axis_tdata_o,  // stat_value
  output logic [dcs_pkg::CODE_W-1:0]  m_axis_tuser_o,  // stat_code
  output logic                        m_axis_tlast_o   // report_end
);

  localparam int SumW = MAX_VOXELS_LOG2 + DOSE_BITS;
  localparam int CntW = MAX_VOXELS_LOG2 + 1;

  // input register
  logic                 vld_q;
  logic [DOSE_BITS-1:0] dose_q;
  logic                 roi_q, tgt_q, org_q, last_q;

  logic          free, retire, s_fire;
  dcs_pkg::upd_t upd;

  logic [DOSE_BITS-1:0]        tgt_min, tgt_max, org_min, org_max;
  logic [SumW-1:0]             tgt_sum, org_sum;
  logic [CntW-1:0]             cnt_nx [dcs_pkg::NUM_LEVELS];
  logic [dcs_pkg::VALUE_W-1:0] vals [dcs_pkg::NUM_STATS];

  // A non-final word always retires; a final one waits for the snapshot.
  assign retire          = vld_q & (!last_q | free);
  assign s_axis_tready_o = !vld_q | retire;
  assign s_fire          = s_axis_tvalid_i & s_axis_tready_o;

  assign upd.apply = retire;
  assign upd.last  = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      dose_q <= s_axis_tdata_i[DOSE_BITS-1:0];
      roi_q  <= s_axis_tuser_i[0];
      tgt_q  <= s_axis_tuser_i[1];
      org_q  <= s_axis_tuser_i[2];
      last_q <= s_axis_tlast_i;
    end
  end

  dcs_track #(
    .DOSE_BITS (DOSE_BITS),
    .SUM_W     (SumW)
  ) u_tgt (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .upd_i    (upd),
    .hit_i    (roi_q & tgt_q),
    .dose_i   (dose_q),
    .min_nx_o (tgt_min),
    .max_nx_o (tgt_max),
    .sum_nx_o (tgt_sum)
  );

  dcs_track #(
    .DOSE_BITS (DOSE_BITS),
    .SUM_W     (SumW)
  ) u_org (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .upd_i    (upd),
    .hit_i    (roi_q & org_q),
    .dose_i   (dose_q),
    .min_nx_o (org_min),
    .max_nx_o (org_max),
    .sum_nx_o (org_sum)
  );

  dcs_level #(
    .DOSE_BITS (DOSE_BITS),
    .CNT_W     (CntW)
  ) u_level (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .upd_i       (upd),
    .hit_i       (roi_q & tgt_q),
    .dose_i      (dose_q),
    .cnt_nx_o    (cnt_nx)
  );

  // Gather the post-update statistics in code order for the snapshot.
  always_comb begin
    vals[dcs_pkg::CODE_TGT_MIN] = dcs_pkg::VALUE_W'(tgt_min);
    vals[dcs_pkg::CODE_TGT_MAX] = dcs_pkg::VALUE_W'(tgt_max);
    vals[dcs_pkg::CODE_TGT_SUM] = dcs_pkg::VALUE_W'(tgt_sum);
    for (int i = 0; i < dcs_pkg::NUM_LEVELS; i++) begin
      vals[int'(dcs_pkg::CODE_LVL_90) + i] = dcs_pkg::VALUE_W'(cnt_nx[i]);
    end
    vals[dcs_pkg::CODE_ORG_MIN] = dcs_pkg::VALUE_W'(org_min);
    vals[dcs_pkg::CODE_ORG_MAX] = dcs_pkg::VALUE_W'(org_max);
    vals[dcs_pkg::CODE_ORG_SUM] = dcs_pkg::VALUE_W'(org_sum);
  end

  dcs_report u_report (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (retire & last_q),
    .vals_i          (vals),
    .free_o          (free),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule

/* verif/dcs_stats_checker.sv */
// ----------------------------------------------------------------------------
// dcs_stats_checker: scoreboard for the dose coverage statistics block
// Watches the prescription writes and both streams, keeps its own copy of the
// per-volume statistics, and compares every report word field by field.
// ----------------------------------------------------------------------------
module dcs_stats_checker #(
  parameter int MAX_VOXELS_LOG2 = 24,
  parameter int DOSE_BITS       = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [dcs_pkg::PRESC_W-1:0]     cfg_wdata_i,
  input  logic                            s_tvalid_i,
  input  logic                            s_tready_i,
  input  logic [((DOSE_BITS+7)/8)*8-1:0]  s_tdata_i,   // voxel_dose
  input  logic [2:0]                      s_tuser_i,   // in_roi, in_target, in_organ
  input  logic                            s_tlast_i,   // final_voxel
  input  logic                            m_tvalid_i,
  input  logic                            m_tready_i,
  input  logic [dcs_pkg::VALUE_W-1:0]     m_tdata_i,   // stat_value
  input  logic [dcs_pkg::CODE_W-1:0]      m_tuser_i,   // stat_code
  input  logic                            m_tlast_i,   // report_end
  input  logic                            flush_i,
  output int                              pending_o,
  output int                              fail_count_o,
  output int                              words_o
);

  localparam int SUM_W = MAX_VOXELS_LOG2 + DOSE_BITS;
  localparam int CNT_W = MAX_VOXELS_LOG2 + 1;

  typedef struct packed {
    dcs_pkg::stat_code_e         code;
    logic [dcs_pkg::VALUE_W-1:0] value;
    logic                        last;
  } stat_word_t;

  int level_steps [dcs_pkg::NUM_LEVELS] = '{90, 95, 98, 100, 105, 107, 110, 120};

  logic [dcs_pkg::PRESC_W-1:0] presc;
  logic [DOSE_BITS-1:0]        tgt_min, tgt_max, org_min, org_max;
  logic [SUM_W-1:0]            tgt_sum, org_sum;
  logic [CNT_W-1:0]            lvl_cnt [dcs_pkg::NUM_LEVELS];

  stat_word_t report_q [$];
  int         errors;
  int         words;
  bit         flushed;

  task automatic report_mismatch(input string msg);
    errors++;
    $display("MISMATCH: %s", msg);
  endtask

  task automatic clear_volume();
    tgt_min = '1;
    tgt_max = '0;
    tgt_sum = '0;
    org_min = '1;
    org_max = '0;
    org_sum = '0;
    for (int i = 0; i < dcs_pkg::NUM_LEVELS; i++) lvl_cnt[i] = '0;
  endtask

  task automatic fold_dose(input logic [DOSE_BITS-1:0] d,
                           inout logic [DOSE_BITS-1:0] mn,
                           inout logic [DOSE_BITS-1:0] mx,
                           inout logic [SUM_W-1:0]     sm);
    logic [SUM_W:0] wide;
    if (d < mn) mn = d;
    if (d > mx) mx = d;
    wide = {1'b0, sm};
    wide = wide + (SUM_W+1)'(d);
    sm   = wide[SUM_W] ? '1 : wide[SUM_W-1:0];
  endtask

  task automatic push_word(input dcs_pkg::stat_code_e code,
                           input logic [dcs_pkg::VALUE_W-1:0] value);
    stat_word_t w;
    w.code  = code;
    w.value = value;
    w.last  = (code == dcs_pkg::CODE_ORG_SUM);
    report_q.push_back(w);
  endtask

  task automatic take_voxel();
    logic [DOSE_BITS-1:0] d;
    logic [47:0]          lhs, rhs;
    d = s_tdata_i[DOSE_BITS-1:0];
    if (s_tuser_i[0] && s_tuser_i[1]) begin
      fold_dose(d, tgt_min, tgt_max, tgt_sum);
      lhs = 48'(d) * 48'd100;
      for (int i = 0; i < dcs_pkg::NUM_LEVELS; i++) begin
        rhs = 48'(presc) * 48'(level_steps[i]);
        if (lhs >= rhs && lvl_cnt[i] != '1) lvl_cnt[i] = lvl_cnt[i] + CNT_W'(1);
      end
    end
    if (s_tuser_i[0] && s_tuser_i[2]) fold_dose(d, org_min, org_max, org_sum);
    if (s_tlast_i) begin
      push_word(dcs_pkg::CODE_TGT_MIN, dcs_pkg::VALUE_W'(tgt_min));
      push_word(dcs_pkg::CODE_TGT_MAX, dcs_pkg::VALUE_W'(tgt_max));
      push_word(dcs_pkg::CODE_TGT_SUM, dcs_pkg::VALUE_W'(tgt_sum));
      for (int i = 0; i < dcs_pkg::NUM_LEVELS; i++)
        push_word(dcs_pkg::stat_code_e'(int'(dcs_pkg::CODE_LVL_90) + i),
                  dcs_pkg::VALUE_W'(lvl_cnt[i]));
      push_word(dcs_pkg::CODE_ORG_MIN, dcs_pkg::VALUE_W'(org_min));
      push_word(dcs_pkg::CODE_ORG_MAX, dcs_pkg::VALUE_W'(org_max));
      push_word(dcs_pkg::CODE_ORG_SUM, dcs_pkg::VALUE_W'(org_sum));
      clear_volume();
    end
  endtask

  task automatic check_word();
    stat_word_t w;
    words++;
    if (report_q.size() == 0) begin
      report_mismatch($sformatf("word %0d: code %0d value %0d arrived with nothing pending",
                                words, m_tuser_i, m_tdata_i));
    end else begin
      w = report_q.pop_front();
      if (m_tuser_i !== w.code)
        report_mismatch($sformatf("word %0d: code %0d, expected %s (%0d)",
                                  words, m_tuser_i, w.code.name(), w.code));
      if (m_tdata_i !== w.value)
        report_mismatch($sformatf("word %0d (%s): value %0d, expected %0d",
                                  words, w.code.name(), m_tdata_i, w.value));
      if (m_tlast_i !== w.last)
        report_mismatch($sformatf("word %0d (%s): tlast %b, expected %b",
                                  words, w.code.name(), m_tlast_i, w.last));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      presc   = '0;
      errors  = 0;
      words   = 0;
      flushed = 1'b0;
      clear_volume();
      report_q.delete();
    end else begin
      if (m_tvalid_i && m_tready_i) check_word();
      if (cfg_we_i) presc = cfg_wdata_i;
      if (s_tvalid_i && s_tready_i) take_voxel();
      if (flush_i && !flushed) begin
        flushed = 1'b1;
        if (report_q.size() != 0)
          report_mismatch($sformatf("%0d report words never arrived", report_q.size()));
      end
    end
    pending_o    <= report_q.size();
    fail_count_o <= errors;
    words_o      <= words;
  end

endmodule

/* verif/tb_dose_coverage_statistics.sv */
// ----------------------------------------------------------------------------
// tb_dose_coverage_statistics: stimulus and verdict for dose coverage stats
// Streams voxel volumes under several prescriptions with random gaps and
// receiver stalls; a checker beside the block scores every report word.
// ----------------------------------------------------------------------------
module tb_dose_coverage_statistics;

  localparam int RANDOM_ITEMS = 330;
  localparam int TB_DOSE_MAX  = 65535;

  logic                          clk_i;
  logic                          rst_ni          = 1'b0;
  logic                          cfg_we_i        = 1'b0;
  logic [dcs_pkg::PRESC_W-1:0]   cfg_wdata_i     = '0;
  logic                          s_axis_tvalid_i = 1'b0;
  logic                          s_axis_tready_o;
  logic [15:0]                   s_axis_tdata_i  = '0;  // voxel_dose
  logic [2:0]                    s_axis_tuser_i  = '0;  // in_roi, in_target, in_organ
  logic                          s_axis_tlast_i  = 1'b0; // final_voxel
  logic                          m_axis_tvalid_o;
  logic                          m_axis_tready_i = 1'b0;
  logic [dcs_pkg::VALUE_W-1:0]   m_axis_tdata_o;  // stat_value
  logic [dcs_pkg::CODE_W-1:0]    m_axis_tuser_o;  // stat_code
  logic                          m_axis_tlast_o;  // report_end

  logic flush   = 1'b0;
  int   pending;
  int   fail_count;
  int   words_seen;

  // Shared knobs: the sender and the receiver idle only while these are set,
  // so some stretches run back to back at full rate.
  bit   tx_gaps_on = 1'b1;
  bit   rx_stall_on = 1'b1;
  int   voxels_sent;
  int   volumes_sent;
  int   presc_writes;

  int   level_steps [dcs_pkg::NUM_LEVELS] = '{90, 95, 98, 100, 105, 107, 110, 120};

  dose_coverage_statistics dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  dcs_stats_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_tvalid_i   (s_axis_tvalid_i),
    .s_tready_i   (s_axis_tready_o),
    .s_tdata_i    (s_axis_tdata_i),
    .s_tuser_i    (s_axis_tuser_i),
    .s_tlast_i    (s_axis_tlast_i),
    .m_tvalid_i   (m_axis_tvalid_o),
    .m_tready_i   (m_axis_tready_i),
    .m_tdata_i    (m_axis_tdata_o),
    .m_tuser_i    (m_axis_tuser_o),
    .m_tlast_i    (m_axis_tlast_o),
    .flush_i      (flush),
    .pending_o    (pending),
    .fail_count_o (fail_count),
    .words_o      (words_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Hard stop well beyond the slowest legal run (every gap and stall at its
  // longest, every volume a full report).
  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

  // Offer one voxel word after a random gap and hold it until it is taken.
  // tvalid is left high on return so that a back-to-back word needs no
  // second assignment in the same step; the next call or a settle drops it.
  task automatic send_voxel(input logic [15:0] dose, input bit roi, input bit tgt,
                            input bit org, input bit last);
    int gap;
    gap = tx_gaps_on ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= dose;
    s_axis_tuser_i  <= {org, tgt, roi};
    s_axis_tlast_i  <= last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    voxels_sent++;
    if (last) volumes_sent++;
  endtask

  // Drop tvalid and hold until every pending report word has drained, then
  // let the input register and the report snapshot empty as well.
  task automatic settle();
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  // Prescription write: one cycle of write enable, then a short pause so the
  // registered level thresholds are in place before the next voxel.
  task automatic write_presc(input logic [dcs_pkg::PRESC_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    repeat (2) @(posedge clk_i);
    presc_writes++;
  endtask

  // Receiver: a fresh stall before each report word.
  initial begin
    int stall;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      stall = rx_stall_on ? $urandom_range(0, 10) : 0;
      if (stall > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
    end
  end

  initial begin
    int          presc;
    int          thr;
    int          len;
    int          budget;
    int          drain;
    logic [15:0] dose;
    bit          roi, tgt, org;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // ---- directed part --------------------------------------------------
    // Prescription still at its reset value of zero.
    // A volume made of one final voxel outside every ROI: its target and
    // organ flags must be ignored and both sets report as empty.
    send_voxel(16'd1234, 1'b0, 1'b1, 1'b1, 1'b1);
    // Zero prescription: even a zero-dose target voxel meets every level.
    send_voxel(16'd0,     1'b1, 1'b1, 1'b0, 1'b0);
    send_voxel(16'hFFFF,  1'b1, 1'b0, 1'b1, 1'b0);
    send_voxel(16'd1,     1'b1, 1'b1, 1'b1, 1'b1);
    settle();

    // Prescription of 1000 puts every level threshold on an exact integer:
    // hit each one on the nose, and the 90 and 120 percent levels just below.
    write_presc(16'd1000);
    send_voxel(16'd900,   1'b1, 1'b1, 1'b0, 1'b0);
    send_voxel(16'd899,   1'b1, 1'b1, 1'b0, 1'b0);
    send_voxel(16'd950,   1'b1, 1'b1, 1'b0, 1'b0);
    send_voxel(16'd980,   1'b1, 1'b1, 1'b0, 1'b0);
    send_voxel(16'd1000,  1'b1, 1'b1, 1'b0, 1'b0);
    send_voxel(16'd1050,  1'b1, 1'b1, 1'b0, 1'b0);
    send_voxel(16'd1070,  1'b1, 1'b1, 1'b0, 1'b0);
    send_voxel(16'd1100,  1'b1, 1'b1, 1'b0, 1'b0);
    send_voxel(16'd1199,  1'b1, 1'b1, 1'b0, 1'b0);
    send_voxel(16'd1200,  1'b1, 1'b1, 1'b0, 1'b0);
    send_voxel(16'd0,     1'b1, 1'b0, 1'b1, 1'b0);
    send_voxel(16'd7,     1'b0, 1'b1, 1'b1, 1'b0);
    // final voxel in both sets: folded in before the report is taken
    send_voxel(16'hFFFF,  1'b1, 1'b1, 1'b1, 1'b1);
    settle();

    // Largest prescription: only the top doses reach the lower levels.
    write_presc(16'hFFFF);
    send_voxel(16'hFFFF,  1'b1, 1'b1, 1'b0, 1'b0);
    send_voxel(16'd58981, 1'b1, 1'b1, 1'b0, 1'b0);
    send_voxel(16'd58982, 1'b1, 1'b1, 1'b1, 1'b1);
    settle();

    // ---- random part ----------------------------------------------------
    budget = voxels_sent + RANDOM_ITEMS;
    while (voxels_sent < budget) begin
      case ($urandom_range(0, 5))
        0:       presc = 0;
        1:       presc = TB_DOSE_MAX;
        2:       presc = $urandom_range(1, 255);
        default: presc = $urandom_range(0, TB_DOSE_MAX);
      endcase
      write_presc(presc[15:0]);

      repeat ($urandom_range(2, 5)) begin
        // mostly short volumes, now and then a longer one
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(16, 40) : $urandom_range(1, 10);
        tx_gaps_on  = ($urandom_range(0, 3) != 0);
        rx_stall_on = ($urandom_range(0, 2) != 0);
        for (int k = 0; k < len; k++) begin
          case ($urandom_range(0, 9))
            0, 1, 2: begin
              // land on, just under or just over a level threshold
              thr = (presc * level_steps[$urandom_range(0, dcs_pkg::NUM_LEVELS - 1)] + 99)
                    / 100;
              thr = thr + $urandom_range(0, 2) - 1;
              if (thr < 0) thr = 0;
              if (thr > TB_DOSE_MAX) thr = TB_DOSE_MAX;
              dose = thr[15:0];
            end
            3:       dose = 16'd0;
            4:       dose = 16'hFFFF;
            default: dose = 16'($urandom_range(0, TB_DOSE_MAX));
          endcase
          // roughly one voxel in five lies outside every ROI
          roi = ($urandom_range(0, 4) != 0);
          tgt = ($urandom_range(0, 1) != 0);
          org = ($urandom_range(0, 1) != 0);
          send_voxel(dose, roi, tgt, org, k == len - 1);
        end
        // hold the sender now and then until the report has fully drained
        if ($urandom_range(0, 3) == 0) settle();
      end
      settle();
    end

    // ---- drain and verdict ----------------------------------------------
    s_axis_tvalid_i <= 1'b0;
    drain = 0;
    do begin
      @(posedge clk_i);
      drain++;
    end while (pending != 0 && drain < 5000);
    repeat (8) @(posedge clk_i);
    flush <= 1'b1;
    repeat (2) @(posedge clk_i);

    $display("Summary: %0d voxels in %0d volumes under %0d prescription settings,",
             voxels_sent, volumes_sent, presc_writes + 1);
    $display("         %0d report words compared against the predicted statistics",
             words_seen);
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
